>>> design/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned PT_W          = 10;
  localparam logic [PT_W-1:0] PT_RESET  = 10'd10;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;

  // function codes of an input beat
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // pin phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_SDA1 = 5'd1,
    PH_ST_SCL1 = 5'd2,
    PH_ST_SDA0 = 5'd3,
    PH_ST_SCL0 = 5'd4,
    PH_TX_SDA  = 5'd5,
    PH_TX_SCL1 = 5'd6,
    PH_TX_SCL0 = 5'd7,
    PH_AK_SDA1 = 5'd8,
    PH_AK_SCL1 = 5'd9,
    PH_AK_READ = 5'd10,
    PH_AK_SCL0 = 5'd11,
    PH_RX_SDA1 = 5'd12,
    PH_RX_SCL1 = 5'd13,
    PH_RX_READ = 5'd14,
    PH_RX_SCL0 = 5'd15,
    PH_MA_SDA  = 5'd16,
    PH_MA_SCL1 = 5'd17,
    PH_MA_SCL0 = 5'd18,
    PH_WAIT    = 5'd19,
    PH_SP_SDA0 = 5'd20,
    PH_SP_SCL1 = 5'd21,
    PH_SP_SDA1 = 5'd22
  } phase_t;

  // which byte of the transaction is on the wire
  typedef enum logic [2:0] {
    STG_DEV  = 3'd0,
    STG_REG  = 3'd1,
    STG_DATA = 3'd2,
    STG_RDEV = 3'd3,
    STG_RX   = 3'd4
  } stage_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       nack_seen;
  } res_t;

endpackage

>>> design/i2c_master_register_access.sv
// Throughput: one tick beat per clock while in_stall is low; each accepted beat advances
// the pin sequencer once, and its result is registered into the output register or skid.
// The two-deep output (register plus skid) takes one more beat while out_stall is high.
// Reset (rst_n low, synchronous): sequencer idle, both pins released high, nack flag clear,
// phase_ticks back to 10, output and skid empty.
module i2c_master_register_access (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [6:0]                    in_dev_addr,
  input  logic [7:0]                    in_reg_addr,
  input  logic [7:0]                    in_wr_data,
  input  logic [7:0]                    in_rd_len,
  input  logic                          in_sda_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scl_out,
  output logic                          out_sda_out,
  output logic                          out_busy_res,
  output logic [7:0]                    out_rd_byte,
  output logic                          out_rd_valid,
  output logic                          out_rd_last,
  output logic                          out_nack_seen,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cm_pkg::ADDR_W-1:0]   paddr,
  input  logic [i2cm_pkg::DATA_W-1:0]   pwdata,
  output logic [i2cm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import i2cm_pkg::*;

  // ---------------------------------------------------------------- config
  logic [PT_W-1:0] phase_ticks_r;
  logic            cfg_hit;

  assign pready  = 1'b1;
  // register 0 occupies byte addresses 0..3
  assign cfg_hit = (paddr[ADDR_W-1] == 1'b0);
  assign prdata  = cfg_hit ? {{(DATA_W-PT_W){1'b0}}, phase_ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      phase_ticks_r <= pwdata[PT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  phase_t          ph_r, ph_nxt;
  stage_t          stage_r, stage_nxt;
  logic [PT_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [2:0]      bit_idx_r, bit_idx_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [7:0]      bytes_left_r, bytes_left_nxt;
  logic            nack_r, nack_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  // held command
  logic            cmd_rd_r, cmd_rd_nxt;
  logic [6:0]      cmd_dev_r, cmd_dev_nxt;
  logic [7:0]      cmd_reg_r, cmd_reg_nxt;
  logic [7:0]      cmd_data_r, cmd_data_nxt;

  logic            in_acc;
  logic            do_enter;
  phase_t          tgt;
  logic [PT_W-1:0] tick_dec;
  logic [PT_W-1:0] tick_load;
  logic [2:0]      bit_sel;
  logic            emit_vld;
  logic            emit_last;
  logic [7:0]      emit_byte;
  res_t            res;

  assign tick_load = (phase_ticks_r == '0) ? {{(PT_W-1){1'b0}}, 1'b1} : phase_ticks_r;
  assign tick_dec  = (tick_cnt_r != '0) ? tick_cnt_r - {{(PT_W-1){1'b0}}, 1'b1} : '0;

  // One tick of the sequencer: pick the next phase, then apply its entry action.
  always_comb begin
    ph_nxt         = ph_r;
    stage_nxt      = stage_r;
    tick_cnt_nxt   = tick_cnt_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    nack_nxt       = nack_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    cmd_rd_nxt     = cmd_rd_r;
    cmd_dev_nxt    = cmd_dev_r;
    cmd_reg_nxt    = cmd_reg_r;
    cmd_data_nxt   = cmd_data_r;
    do_enter       = 1'b0;
    tgt            = PH_IDLE;
    emit_vld       = 1'b0;
    emit_last      = 1'b0;
    emit_byte      = '0;

    if (ph_r == PH_IDLE) begin
      if (in_func == FUNC_WRITE || in_func == FUNC_READ) begin
        cmd_rd_nxt     = (in_func == FUNC_READ);
        cmd_dev_nxt    = in_dev_addr;
        cmd_reg_nxt    = in_reg_addr;
        cmd_data_nxt   = in_wr_data;
        bytes_left_nxt = (in_rd_len == '0) ? 8'd1 : in_rd_len;
        nack_nxt       = 1'b0;
        stage_nxt      = STG_DEV;
        bit_idx_nxt    = '0;
        shift_nxt      = '0;
        do_enter       = 1'b1;
        tgt            = PH_ST_SDA1;
      end
    end else begin
      tick_cnt_nxt = tick_dec;
      if (tick_dec == '0) begin
        do_enter = 1'b1;
        unique case (ph_r)
          PH_ST_SDA1: tgt = PH_ST_SCL1;
          PH_ST_SCL1: tgt = PH_ST_SDA0;
          PH_ST_SDA0: tgt = PH_ST_SCL0;
          PH_ST_SCL0: begin
            bit_idx_nxt = '0;
            tgt         = PH_TX_SDA;
            if (stage_r == STG_DEV) begin
              shift_nxt = {cmd_dev_r, 1'b0};
            end else begin
              stage_nxt = STG_RDEV;
              shift_nxt = {cmd_dev_r, 1'b1};
            end
          end
          PH_TX_SDA:  tgt = PH_TX_SCL1;
          PH_TX_SCL1: tgt = PH_TX_SCL0;
          PH_TX_SCL0: begin
            if (bit_idx_r == 3'd7) begin
              tgt = PH_AK_SDA1;
            end else begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              tgt         = PH_TX_SDA;
            end
          end
          PH_AK_SDA1: tgt = PH_AK_SCL1;
          PH_AK_SCL1: tgt = PH_AK_READ;
          PH_AK_READ: tgt = PH_AK_SCL0;
          PH_AK_SCL0: begin
            priority if (stage_r == STG_DEV) begin
              stage_nxt   = STG_REG;
              shift_nxt   = cmd_reg_r;
              bit_idx_nxt = '0;
              tgt         = PH_TX_SDA;
            end else if (stage_r == STG_REG) begin
              stage_nxt = STG_DATA;
              if (cmd_rd_r) begin
                tgt = PH_ST_SDA1;
              end else begin
                shift_nxt   = cmd_data_r;
                bit_idx_nxt = '0;
                tgt         = PH_TX_SDA;
              end
            end else if (stage_r == STG_RDEV) begin
              stage_nxt   = STG_RX;
              shift_nxt   = '0;
              bit_idx_nxt = '0;
              tgt         = PH_RX_SDA1;
            end else begin
              tgt = PH_SP_SDA0;
            end
          end
          PH_RX_SDA1: tgt = PH_RX_SCL1;
          PH_RX_SCL1: tgt = PH_RX_READ;
          PH_RX_READ: tgt = PH_RX_SCL0;
          PH_RX_SCL0: begin
            if (bit_idx_r == 3'd7) begin
              tgt = PH_MA_SDA;
            end else begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              tgt         = PH_RX_SCL1;
            end
          end
          PH_MA_SDA:  tgt = PH_MA_SCL1;
          PH_MA_SCL1: tgt = PH_MA_SCL0;
          PH_MA_SCL0: begin
            if (bytes_left_r <= 8'd1) begin
              bytes_left_nxt = '0;
              tgt            = PH_WAIT;
            end else begin
              bytes_left_nxt = bytes_left_r - 8'd1;
              shift_nxt      = '0;
              bit_idx_nxt    = '0;
              tgt            = PH_RX_SDA1;
            end
          end
          PH_WAIT:    tgt = PH_SP_SDA0;
          PH_SP_SDA0: tgt = PH_SP_SCL1;
          PH_SP_SCL1: tgt = PH_SP_SDA1;
          default: begin
            // end of stop condition
            do_enter     = 1'b0;
            ph_nxt       = PH_IDLE;
            tick_cnt_nxt = '0;
            stage_nxt    = STG_DEV;
          end
        endcase
      end
    end

    bit_sel = 3'd7 - bit_idx_nxt;
    if (do_enter) begin
      ph_nxt       = tgt;
      tick_cnt_nxt = tick_load;
      unique case (tgt)
        PH_ST_SDA1, PH_AK_SDA1, PH_RX_SDA1, PH_SP_SDA1: sda_nxt = 1'b1;
        PH_ST_SDA0, PH_SP_SDA0:                         sda_nxt = 1'b0;
        PH_ST_SCL1, PH_TX_SCL1, PH_AK_SCL1, PH_RX_SCL1,
        PH_MA_SCL1, PH_SP_SCL1:                         scl_nxt = 1'b1;
        PH_ST_SCL0, PH_TX_SCL0, PH_AK_SCL0, PH_RX_SCL0,
        PH_MA_SCL0:                                     scl_nxt = 1'b0;
        PH_TX_SDA:  sda_nxt = shift_nxt[bit_sel];
        PH_AK_READ: begin
          if (in_sda_in) nack_nxt = 1'b1;
        end
        PH_RX_READ: begin
          shift_nxt[bit_sel] = shift_nxt[bit_sel] | in_sda_in;
          if (bit_idx_nxt == 3'd7) begin
            emit_vld  = 1'b1;
            emit_byte = shift_nxt;
            emit_last = (bytes_left_nxt <= 8'd1);
          end
        end
        PH_MA_SDA:  sda_nxt = (bytes_left_nxt <= 8'd1);  // NACK on the last byte
        default: ;
      endcase
    end

    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (ph_nxt != PH_IDLE);
    res.rd_byte   = emit_byte;
    res.rd_valid  = emit_vld;
    res.rd_last   = emit_last;
    res.nack_seen = nack_nxt;
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_IDLE;
      stage_r      <= STG_DEV;
      tick_cnt_r   <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      nack_r       <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      cmd_rd_r     <= 1'b0;
      cmd_dev_r    <= '0;
      cmd_reg_r    <= '0;
      cmd_data_r   <= '0;
    end else if (in_acc) begin
      ph_r         <= ph_nxt;
      stage_r      <= stage_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      nack_r       <= nack_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      cmd_rd_r     <= cmd_rd_nxt;
      cmd_dev_r    <= cmd_dev_nxt;
      cmd_reg_r    <= cmd_reg_nxt;
      cmd_data_r   <= cmd_data_nxt;
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic out_vld_r;
  logic skid_vld_r;
  res_t out_r;
  res_t skid_r;
  logic out_take;

  assign out_take = out_vld_r && !out_stall;
  // input stalls only once the skid beat is occupied
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_take && skid_vld_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_scl_out   = out_r.scl_out;
  assign out_sda_out   = out_r.sda_out;
  assign out_busy_res  = out_r.busy_res;
  assign out_rd_byte   = out_r.rd_byte;
  assign out_rd_valid  = out_r.rd_valid;
  assign out_rd_last   = out_r.rd_last;
  assign out_nack_seen = out_r.nack_seen;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid beat held with output register empty");

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_IDLE) |-> (tick_cnt_r == '0))
    else $error("tick counter running while idle");

  a_busy_counting: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_IDLE) |-> (tick_cnt_r != '0))
    else $error("phase active with expired tick counter");

  a_emit_in_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit_vld) |-> (ph_nxt == PH_RX_READ && stage_r == STG_RX))
    else $error("read byte emitted outside a receive bit");

endmodule

>>> tb/sv/i2cm_bus_checker.sv
// Watches the tick and result channels and the register port, predicts the pin
// levels and read bytes of every tick beat, and compares them as they come out.
module i2cm_bus_checker #(
  parameter logic [i2cm_pkg::ADDR_W-1:0] PT_ADDR = '0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [6:0]                  in_dev_addr,
  input  logic [7:0]                  in_reg_addr,
  input  logic [7:0]                  in_wr_data,
  input  logic [7:0]                  in_rd_len,
  input  logic                        in_sda_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_scl_out,
  input  logic                        out_sda_out,
  input  logic                        out_busy_res,
  input  logic [7:0]                  out_rd_byte,
  input  logic                        out_rd_valid,
  input  logic                        out_rd_last,
  input  logic                        out_nack_seen,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cm_pkg::ADDR_W-1:0] paddr,
  input  logic [i2cm_pkg::DATA_W-1:0] pwdata,
  input  logic [i2cm_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        run_over,
  output int                          fail_cnt,
  output int                          pending,
  output int                          beats_taken,
  output int                          bytes_read,
  output logic                        bus_busy,
  output logic                        closing_tick
);
  import i2cm_pkg::*;

  res_t line_q[$];
  res_t want;
  logic [DATA_W-1:0] rd_want;
  int results_seen;
  bit over_noted;

  // predicted sequencer
  logic [PT_W-1:0] pt_reg;
  phase_t          ph;
  stage_t          stg;
  logic [9:0]      tcnt;
  logic [2:0]      bidx;
  logic [7:0]      shreg;
  logic [7:0]      bytes_due;
  logic            c_rd;
  logic [6:0]      c_dev;
  logic [7:0]      c_reg;
  logic [7:0]      c_dat;
  logic            nack;
  logic            scl;
  logic            sda;
  logic            smp_sda;
  logic            ev_valid;
  logic [7:0]      ev_byte;
  logic            ev_last;

  task automatic report_fail(input string msg);
    if (fail_cnt < 200) $display("%0t ERROR %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v)
      report_fail($sformatf("result beat %0d, %s: got %0h, want %0h",
                            results_seen, name, got, exp_v));
  endtask

  function automatic void model_reset();
    pt_reg    = PT_RESET;
    ph        = PH_IDLE;
    stg       = STG_DEV;
    tcnt      = '0;
    bidx      = '0;
    shreg     = '0;
    bytes_due = '0;
    c_rd      = 1'b0;
    c_dev     = '0;
    c_reg     = '0;
    c_dat     = '0;
    nack      = 1'b0;
    scl       = 1'b1;
    sda       = 1'b1;
  endfunction

  function automatic void enter_phase(input phase_t p);
    ph   = p;
    tcnt = (pt_reg == '0) ? 10'd1 : pt_reg;
    case (p)
      PH_ST_SDA1, PH_AK_SDA1, PH_RX_SDA1, PH_SP_SDA1: sda = 1'b1;
      PH_ST_SDA0, PH_SP_SDA0: sda = 1'b0;
      PH_ST_SCL1, PH_TX_SCL1, PH_AK_SCL1, PH_RX_SCL1, PH_MA_SCL1, PH_SP_SCL1: scl = 1'b1;
      PH_ST_SCL0, PH_TX_SCL0, PH_AK_SCL0, PH_RX_SCL0, PH_MA_SCL0: scl = 1'b0;
      PH_TX_SDA: sda = shreg[3'd7 - bidx];
      PH_AK_READ: if (smp_sda) nack = 1'b1;
      PH_RX_READ: begin
        if (smp_sda) shreg[3'd7 - bidx] = 1'b1;
        if (bidx == 3'd7) begin
          ev_valid = 1'b1;
          ev_byte  = shreg;
          ev_last  = (bytes_due <= 8'd1);
        end
      end
      PH_MA_SDA: sda = (bytes_due <= 8'd1);
      default: ;
    endcase
  endfunction

  function automatic void send_byte(input logic [7:0] b);
    shreg = b;
    bidx  = '0;
    enter_phase(PH_TX_SDA);
  endfunction

  function automatic void recv_byte();
    shreg = '0;
    bidx  = '0;
    enter_phase(PH_RX_SDA1);
  endfunction

  function automatic void next_phase();
    case (ph)
      PH_ST_SDA1: enter_phase(PH_ST_SCL1);
      PH_ST_SCL1: enter_phase(PH_ST_SDA0);
      PH_ST_SDA0: enter_phase(PH_ST_SCL0);
      PH_ST_SCL0: begin
        if (stg == STG_DEV) begin
          send_byte({c_dev, 1'b0});
        end else begin
          stg = STG_RDEV;
          send_byte({c_dev, 1'b1});
        end
      end
      PH_TX_SDA:  enter_phase(PH_TX_SCL1);
      PH_TX_SCL1: enter_phase(PH_TX_SCL0);
      PH_TX_SCL0: begin
        if (bidx == 3'd7) begin
          enter_phase(PH_AK_SDA1);
        end else begin
          bidx++;
          enter_phase(PH_TX_SDA);
        end
      end
      PH_AK_SDA1: enter_phase(PH_AK_SCL1);
      PH_AK_SCL1: enter_phase(PH_AK_READ);
      PH_AK_READ: enter_phase(PH_AK_SCL0);
      PH_AK_SCL0: begin
        if (stg == STG_DEV) begin
          stg = STG_REG;
          send_byte(c_reg);
        end else if (stg == STG_REG) begin
          stg = STG_DATA;
          if (c_rd) enter_phase(PH_ST_SDA1);
          else send_byte(c_dat);
        end else if (stg == STG_RDEV) begin
          stg = STG_RX;
          recv_byte();
        end else begin
          enter_phase(PH_SP_SDA0);
        end
      end
      PH_RX_SDA1: enter_phase(PH_RX_SCL1);
      PH_RX_SCL1: enter_phase(PH_RX_READ);
      PH_RX_READ: enter_phase(PH_RX_SCL0);
      PH_RX_SCL0: begin
        if (bidx == 3'd7) begin
          enter_phase(PH_MA_SDA);
        end else begin
          bidx++;
          enter_phase(PH_RX_SCL1);
        end
      end
      PH_MA_SDA:  enter_phase(PH_MA_SCL1);
      PH_MA_SCL1: enter_phase(PH_MA_SCL0);
      PH_MA_SCL0: begin
        if (bytes_due <= 8'd1) begin
          bytes_due = '0;
          enter_phase(PH_WAIT);
        end else begin
          bytes_due = bytes_due - 8'd1;
          recv_byte();
        end
      end
      PH_WAIT:    enter_phase(PH_SP_SDA0);
      PH_SP_SDA0: enter_phase(PH_SP_SCL1);
      PH_SP_SCL1: enter_phase(PH_SP_SDA1);
      default: begin
        ph   = PH_IDLE;
        tcnt = '0;
        stg  = STG_DEV;
      end
    endcase
  endfunction

  // one tick of the bus; commands only start from idle
  function automatic res_t bus_step(input logic [1:0] f, input logic [6:0] dev,
                                    input logic [7:0] ra, input logic [7:0] wd,
                                    input logic [7:0] len, input logic s);
    res_t r;
    smp_sda  = s;
    ev_valid = 1'b0;
    ev_byte  = '0;
    ev_last  = 1'b0;
    if (ph == PH_IDLE) begin
      if (f == FUNC_WRITE || f == FUNC_READ) begin
        c_rd      = (f == FUNC_READ);
        c_dev     = dev;
        c_reg     = ra;
        c_dat     = wd;
        bytes_due = (len == 8'd0) ? 8'd1 : len;
        nack      = 1'b0;
        stg       = STG_DEV;
        bidx      = '0;
        shreg     = '0;
        enter_phase(PH_ST_SDA1);
      end
    end else begin
      if (tcnt != '0) tcnt = tcnt - 10'd1;
      if (tcnt == '0) next_phase();
    end
    r.scl_out   = scl;
    r.sda_out   = sda;
    r.busy_res  = (ph != PH_IDLE);
    r.rd_byte   = ev_byte;
    r.rd_valid  = ev_valid;
    r.rd_last   = ev_last;
    r.nack_seen = nack;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      model_reset();
      line_q.delete();
    end else begin
      // result side first: a beat taken now cannot show up at this same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (line_q.size() == 0) begin
          report_fail($sformatf("result beat %0d with no tick beat waiting", results_seen));
        end else begin
          want = line_q.pop_front();
          check_field("scl_out",   8'(out_scl_out),   8'(want.scl_out));
          check_field("sda_out",   8'(out_sda_out),   8'(want.sda_out));
          check_field("busy_res",  8'(out_busy_res),  8'(want.busy_res));
          check_field("rd_byte",   out_rd_byte,       want.rd_byte);
          check_field("rd_valid",  8'(out_rd_valid),  8'(want.rd_valid));
          check_field("rd_last",   8'(out_rd_last),   8'(want.rd_last));
          check_field("nack_seen", 8'(out_nack_seen), 8'(want.nack_seen));
          if (want.rd_valid) bytes_read++;
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == PT_ADDR) pt_reg = pwdata[PT_W-1:0];
        end else begin
          rd_want = '0;
          rd_want[PT_W-1:0] = pt_reg;
          if (prdata !== rd_want)
            report_fail($sformatf("phase_ticks read back %0h, want %0h", prdata, rd_want));
        end
      end
      if (in_valid && !in_stall) begin
        line_q.push_back(bus_step(in_func, in_dev_addr, in_reg_addr, in_wr_data,
                                  in_rd_len, in_sda_in));
        beats_taken++;
      end
      if (run_over && !over_noted) begin
        over_noted = 1'b1;
        if (line_q.size() != 0)
          report_fail($sformatf("%0d result beats never came out", line_q.size()));
      end
    end
    pending      = line_q.size();
    bus_busy     = (ph != PH_IDLE);
    closing_tick = (ph == PH_SP_SDA1) && (tcnt <= 10'd1);
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import i2cm_pkg::*;

  // phase_ticks is register 0
  localparam logic [ADDR_W-1:0] PT_ADDR = '0;
  // func code 3 is spare: the block treats it as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RAND_BEATS = 600;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // tick channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = FUNC_TICK;
  logic [6:0] in_dev_addr = '0;
  logic [7:0] in_reg_addr = '0;
  logic [7:0] in_wr_data = '0;
  logic [7:0] in_rd_len = '0;
  logic       in_sda_in = 1'b1;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic [7:0] out_rd_byte;
  logic       out_rd_valid;
  logic       out_rd_last;
  logic       out_nack_seen;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // from the checker
  logic run_over = 1'b0;
  int   fail_cnt;
  int   pending;
  int   beats_taken;
  int   bytes_read;
  logic bus_busy;
  logic closing_tick;

  // sender pacing and stimulus bookkeeping
  int burst_left = 0;
  int sda_mode = 0;   // 0 random line, 1 slave holds SDA low, 2 line floats high
  int n_wr = 0;
  int n_rd = 0;
  int rand_start;
  int iter;
  logic [1:0] rfunc;
  logic [7:0] rlen;

  // receiver stall pattern and the long hold-off
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   pat_left = 0;
  int   pat_kind = 0;

  always #4 clk = ~clk;

  i2c_master_register_access dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_dev_addr  (in_dev_addr),
    .in_reg_addr  (in_reg_addr),
    .in_wr_data   (in_wr_data),
    .in_rd_len    (in_rd_len),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_rd_byte  (out_rd_byte),
    .out_rd_valid (out_rd_valid),
    .out_rd_last  (out_rd_last),
    .out_nack_seen(out_nack_seen),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  i2cm_bus_checker #(.PT_ADDR(PT_ADDR)) bus_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_dev_addr  (in_dev_addr),
    .in_reg_addr  (in_reg_addr),
    .in_wr_data   (in_wr_data),
    .in_rd_len    (in_rd_len),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_rd_byte  (out_rd_byte),
    .out_rd_valid (out_rd_valid),
    .out_rd_last  (out_rd_last),
    .out_nack_seen(out_nack_seen),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .run_over     (run_over),
    .fail_cnt     (fail_cnt),
    .pending      (pending),
    .beats_taken  (beats_taken),
    .bytes_read   (bytes_read),
    .bus_busy     (bus_busy),
    .closing_tick (closing_tick)
  );

  // Receiver: stall pattern changes at random intervals between no stall,
  // light random, heavy random and alternating. A toggle of hold_req starts a
  // long hold-off counted here, so the output buffer fills and in_stall rises.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (pat_left == 0) begin
      pat_kind = $urandom_range(0, 3);
      pat_left = $urandom_range(10, 150);
    end else begin
      pat_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (pat_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= pat_left[0];
      endcase
    end
  end

  // Sender. Called and returning at a falling edge. On return the accepted
  // beat is still on the pins with in_valid high: the caller must either drive
  // the next beat or drop in_valid in that same step. Bursts of random length,
  // with a random gap (sometimes none) before each burst.
  task automatic send_beat(input logic [1:0] f, input logic [6:0] dev,
                           input logic [7:0] ra, input logic [7:0] wd,
                           input logic [7:0] len, input logic s);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_dev_addr <= dev;
    in_reg_addr <= ra;
    in_wr_data  <= wd;
    in_rd_len   <= len;
    in_sda_in   <= s;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
  endtask

  // SDA level the "slave" puts on the line this tick
  function automatic logic pick_sda();
    case (sda_mode)
      1: return 1'b0;
      2: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // a beat whose command fields carry random junk
  task automatic send_filler(input logic [1:0] f);
    send_beat(f, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_sda());
  endtask

  // Start a command from idle and tick it through to the end. With noise on,
  // some busy ticks carry a write, read or spare command that must be ignored.
  task automatic run_cmd(input logic [1:0] f, input logic [6:0] dev, input logic [7:0] ra,
                         input logic [7:0] wd, input logic [7:0] len, input logic noise);
    send_beat(f, dev, ra, wd, len, pick_sda());
    if (f == FUNC_WRITE) n_wr++;
    else if (f == FUNC_READ) n_rd++;
    while (bus_busy) begin
      if (noise && $urandom_range(0, 5) == 0) send_filler(2'($urandom_range(1, 3)));
      else send_filler(FUNC_TICK);
    end
  endtask

  // drop valid and let every predicted beat drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  // setup cycle then access cycle; leaves psel high, the caller releases it
  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PT_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // write phase_ticks and read it straight back (checker compares the read)
  task automatic set_phase_ticks(input logic [DATA_W-1:0] v);
    settle();
    apb_access(1'b1, v);
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset value of phase_ticks, then a few idle beats at the default rate
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    send_filler(FUNC_TICK);
    send_filler(FUNC_SPARE);

    // fastest rate: all-ACK write of ones, all-NACK write of zeros, reads of
    // 0 (taken as 1), 1 and 3 bytes
    set_phase_ticks(1);
    sda_mode = 1;
    run_cmd(FUNC_WRITE, 7'h7f, 8'hff, 8'hff, 8'd1, 1'b0);
    sda_mode = 2;
    run_cmd(FUNC_WRITE, 7'h00, 8'h00, 8'h00, 8'd1, 1'b0);
    sda_mode = 0;
    run_cmd(FUNC_READ, 7'h55, 8'haa, 8'h5a, 8'd0, 1'b0);
    sda_mode = 2;
    run_cmd(FUNC_READ, 7'h2a, 8'h55, 8'h00, 8'd1, 1'b0);
    sda_mode = 1;
    run_cmd(FUNC_READ, 7'h7f, 8'h00, 8'h00, 8'd3, 1'b0);

    // spare code and plain ticks while idle do nothing
    sda_mode = 0;
    send_filler(FUNC_SPARE);
    send_filler(FUNC_TICK);

    // a write from idle, then commands on busy beats and on the very beat the STOP
    // finishes (all ignored), then one on the first idle beat, which is taken
    send_beat(FUNC_WRITE, 7'h12, 8'h34, 8'h56, 8'd1, pick_sda());
    n_wr++;
    send_beat(FUNC_READ, 7'h3c, 8'hc3, 8'h00, 8'd4, pick_sda());
    send_filler(FUNC_SPARE);
    while (!closing_tick) send_filler(FUNC_TICK);
    send_beat(FUNC_WRITE, 7'h61, 8'h16, 8'h99, 8'd2, pick_sda());
    send_beat(FUNC_READ, 7'h0f, 8'hf0, 8'h00, 8'd2, pick_sda());
    n_rd++;
    while (bus_busy) send_filler(FUNC_TICK);

    // zero phase length behaves as one
    set_phase_ticks(0);
    run_cmd(FUNC_READ, 7'h33, 8'h77, 8'h00, 8'd2, 1'b0);

    // slowest rate: load and read back, idle beats only
    set_phase_ticks(1023);
    send_filler(FUNC_TICK);
    send_filler(FUNC_SPARE);
    send_filler(FUNC_TICK);

    // bits above the 10-bit field are dropped: this lands as 2
    set_phase_ticks(32'hffff_fc02);
    run_cmd(FUNC_WRITE, 7'h5a, 8'h0f, 8'hf0, 8'd7, 1'b0);

    // Random part: mostly short commands at fast rates with random content,
    // junk commands sprinkled over busy beats, a few idle and spare beats.
    rand_start = beats_taken;
    iter = 0;
    while (beats_taken - rand_start < RAND_BEATS) begin
      if ($urandom_range(0, 4) == 0) set_phase_ticks($urandom_range(0, 3));
      repeat ($urandom_range(0, 2))
        send_filler($urandom_range(0, 1) ? FUNC_TICK : FUNC_SPARE);
      sda_mode = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
      rfunc = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      rlen = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 3));
      if (iter == 0) hold_req <= ~hold_req;
      run_cmd(rfunc, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), rlen, 1'b1);
      iter++;
    end

    // drain, wait on for stray beats, then have the checker
    // flag anything still waiting
    settle();
    repeat (4) @(negedge clk);
    run_over <= 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("covered %0d register writes and %0d burst reads, %0d bytes read back,",
             n_wr, n_rd, bytes_read);
    $display("%0d tick beats at phase lengths 0 to 1023, busy-time commands, a long hold-off",
             beats_taken);
    if (fail_cnt == 0) begin
      $display("i2c_master_register_access regression: pass");
    end else begin
      $display("i2c_master_register_access regression: fail");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40_000_000;
    $display("i2c_master_register_access regression: fail");
    $finish;
  end

endmodule
